// ----- rtl/lobm_pkg.sv -----
// Package: types, codes and helpers for the order book matcher.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

    localparam int BookEntriesDef = 32;
    localparam int MaxFills       = 32;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_CANCEL = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        K_TRADE    = 3'd0,
        K_RESTED   = 3'd1,
        K_FILLED   = 3'd2,
        K_REJECTED = 3'd3,
        K_CANCELLED = 3'd4,
        K_NOTFOUND = 3'd5
    } t_kind;

    typedef struct packed {
        logic        op;
        logic [31:0] order_id;
        logic        side;
        logic [15:0] limit_price;
        logic [31:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [15:0] trade_price;
        logic [31:0] trade_quantity;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_FREE,
        S_DONE,
        S_CANCEL
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/lobm_queue.sv -----
// Two-entry transaction queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lobm_queue
    import lobm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_in_item      o_data
);
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lobm_engine.sv -----
// Back end: book storage, best-order scan, fills, resting and cancels.
`timescale 1ns / 1ps
`default_nettype none
module lobm_engine
    import lobm_pkg::*;
#(
    parameter int BOOK_ENTRIES = BookEntriesDef
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_data
);
    localparam int IW = $clog2(BOOK_ENTRIES);
    localparam int FW = $clog2(MaxFills + 1);

    logic [BOOK_ENTRIES-1:0] r_valid;
    logic        r_side  [BOOK_ENTRIES];
    logic [31:0] r_id    [BOOK_ENTRIES];
    logic [15:0] r_price [BOOK_ENTRIES];
    logic [31:0] r_rem   [BOOK_ENTRIES];
    logic [31:0] r_arr   [BOOK_ENTRIES];
    logic [31:0] r_ctr;

    t_state   r_st, n_st;
    t_in_item r_cur;
    logic [31:0] r_left;
    logic [IW-1:0] r_idx;      // scan pointer
    logic [IW-1:0] r_best;
    logic          r_has;
    logic          r_found;
    logic [FW-1:0] r_nf;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_out;

    logic          w_take, w_out_free;
    logic          w_cand, w_better;
    logic [31:0]   w_age_i, w_age_b, w_fill;
    logic          w_last_idx;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_valid    = r_ovalid;
    assign o_data     = r_out;
    assign o_stall    = (r_st != S_IDLE);
    assign w_take     = i_valid && (r_st == S_IDLE);
    assign w_last_idx = (r_idx == IW'(BOOK_ENTRIES - 1));

    always_comb begin
        w_cand = r_valid[r_idx] && (r_side[r_idx] != r_cur.side) &&
                 (r_cur.side ? (r_price[r_idx] >= r_cur.limit_price)
                             : (r_price[r_idx] <= r_cur.limit_price));
        w_age_i = r_ctr - r_arr[r_idx];
        w_age_b = r_ctr - r_arr[r_best];
        if (!r_has) begin
            w_better = 1'b1;
        end else if (r_price[r_idx] != r_price[r_best]) begin
            w_better = r_cur.side ? (r_price[r_idx] > r_price[r_best])
                                  : (r_price[r_idx] < r_price[r_best]);
        end else begin
            w_better = w_age_i > w_age_b;
        end
        w_fill = (r_left < r_rem[r_best]) ? r_left : r_rem[r_best];
    end

    // output register: held while stalled, loaded by a trade or a completion
    always_comb begin
        n_ovalid = r_ovalid && i_stall;
        if (((r_st == S_FILL) || (r_st == S_DONE)) && w_out_free) n_ovalid = 1'b1;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (w_take) begin
                    if (i_data.op == OP_CANCEL) n_st = S_CANCEL;
                    else if (i_data.quantity == 32'd0) n_st = S_DONE;
                    else n_st = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last_idx) begin
                    if (r_has || (w_cand && w_better)) n_st = S_FILL;
                    else n_st = S_FREE;
                end
            end
            S_FILL: begin
                if (w_out_free) begin
                    if (r_left == w_fill) n_st = S_DONE;
                    else if (r_nf == FW'(MaxFills - 1)) n_st = S_FREE;
                    else n_st = S_SCAN;
                end
            end
            S_FREE: begin
                if (!r_valid[r_idx] || w_last_idx) n_st = S_DONE;
            end
            S_CANCEL: begin
                if (w_last_idx) n_st = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_valid  <= '0;
            r_ctr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
            unique case (r_st)
                S_IDLE: begin
                    r_cur   <= i_data;
                    r_left  <= i_data.quantity;
                    r_idx   <= '0;
                    r_has   <= 1'b0;
                    r_found <= 1'b0;
                    r_nf    <= '0;
                end
                S_SCAN: begin
                    if (w_cand && w_better) begin
                        r_best <= r_idx;
                        r_has  <= 1'b1;
                    end
                    r_idx <= w_last_idx ? '0 : r_idx + 1'b1;
                end
                S_FILL: begin
                    if (w_out_free) begin
                        r_out.kind <= K_TRADE;
                        r_out.buyer_id  <= r_cur.side ? r_id[r_best] : r_cur.order_id;
                        r_out.seller_id <= r_cur.side ? r_cur.order_id : r_id[r_best];
                        r_out.trade_price    <= r_price[r_best];
                        r_out.trade_quantity <= w_fill;
                        r_out.last <= 1'b0;
                        r_left <= r_left - w_fill;
                        r_rem[r_best] <= r_rem[r_best] - w_fill;
                        if (r_rem[r_best] == w_fill) r_valid[r_best] <= 1'b0;
                        r_nf  <= r_nf + 1'b1;
                        r_has <= 1'b0;
                        r_idx <= '0;
                    end
                end
                S_FREE: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                        r_side[r_idx]  <= r_cur.side;
                        r_id[r_idx]    <= r_cur.order_id;
                        r_price[r_idx] <= r_cur.limit_price;
                        r_rem[r_idx]   <= r_left;
                        r_arr[r_idx]   <= r_ctr;
                        r_ctr   <= r_ctr + 32'd1;
                        r_found <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CANCEL: begin
                    if (r_valid[r_idx] && r_id[r_idx] == r_cur.order_id) begin
                        r_valid[r_idx] <= 1'b0;
                        r_found <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.buyer_id    <= '0;
                        r_out.seller_id   <= '0;
                        r_out.trade_price <= '0;
                        r_out.last        <= 1'b1;
                        if (r_cur.op == OP_CANCEL) begin
                            r_out.kind <= r_found ? K_CANCELLED : K_NOTFOUND;
                            r_out.trade_quantity <= '0;
                        end else if (r_left == 32'd0) begin
                            r_out.kind <= K_FILLED;
                            r_out.trade_quantity <= '0;
                        end else begin
                            r_out.kind <= r_found ? K_RESTED : K_REJECTED;
                            r_out.trade_quantity <= r_left;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/limit_order_book_matcher.sv -----
// Top level: price-time priority limit order book matcher.
`timescale 1ns / 1ps
`default_nettype none
// Orders (add or cancel) enter through a two-deep queue into a sequential
// engine holding BOOK_ENTRIES resting slots. An add scans all slots once
// per fill to find the best crossing order, emits one trade, and repeats
// until it is fully filled, no crossing order is left or MaxFills trades
// are made; unless fully filled, it then searches for the lowest free
// slot. Either way it emits one completion with last = 1. A cancel takes
// one pass over the slots. The scan uses a single slot-compare path.
// Results leave through an output register; a stall there holds the
// engine. No clearing pass after reset: slot valid bits clear at once.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int BOOK_ENTRIES = BookEntriesDef
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data
);
    logic     w_q_valid, w_q_stall;
    t_in_item w_q_data;

    // front: accept and hold transactions
    lobm_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid (i_valid),  .o_stall (o_stall), .i_data (i_data),
        .o_valid (w_q_valid), .i_stall (w_q_stall), .o_data (w_q_data)
    );

    // back: matching engine
    lobm_engine #(.BOOK_ENTRIES(BOOK_ENTRIES)) u_engine (
        .i_clk, .i_rst_n,
        .i_valid (w_q_valid), .o_stall (w_q_stall), .i_data (w_q_data),
        .o_valid (o_valid),   .i_stall (i_stall),   .o_data (o_data)
    );

`ifndef ASSERT_OFF
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.kind <= K_NOTFOUND)) else $error("bad kind");
    a_trade_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == K_TRADE) |-> !o_data.last)
        else $error("trade marked last");
    a_trade_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == K_TRADE) |-> (o_data.trade_quantity != 0))
        else $error("empty trade");
`endif
endmodule
`default_nettype wire
